@@ rtl/dq_pkg.sv @@
// Shared types and constants for the double-ended queue.
package dq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST       = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Commands from the controller to the datapath; at most one is set per cycle.
  typedef struct packed {
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    list_step;
    logic    report;
    status_t report_status;
  } dq_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic list_last;
    logic out_free;
  } dq_stat_t;

endpackage

@@ rtl/dq_if.sv @@
// Request and result channel interfaces of the double-ended queue.
interface dq_req_if import dq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_out;
  logic [STATUS_W-1:0]       status;
  logic                      last;

  modport source (output valid, output value_out, output status, output last, input ready);
  modport sink (input valid, input value_out, input status, input last, output ready);
endinterface

@@ rtl/dq_datapath.sv @@
// Ring store, pointers, list index and output register of the double-ended queue.
module dq_datapath import dq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  dq_cmd_t                   cmd,
  input  logic signed [VALUE_W-1:0] push_value,
  input  logic                      out_ready,
  output dq_stat_t                  stat,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [STATUS_W-1:0]       out_status,
  output logic                      out_last
);

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [IDX_W-1:0]   front;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   list_idx;
  logic [CNT_W-1:0]   offset;
  logic [IDX_W-1:0]   addr;
  logic [IDX_W-1:0]   front_inc;
  logic               emit;
  logic               mem_read;

  // Modular add of a slot and an offset of at most one full ring.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  // Offset from the front slot for the slot that this command touches.
  always_comb begin
    offset = '0;
    if (cmd.push_front) begin
      offset = CNT_W'(CAPACITY - 1);
    end else if (cmd.push_back) begin
      offset = count;
    end else if (cmd.pop_back) begin
      offset = count - CNT_W'(1);
    end else if (cmd.list_step) begin
      offset = CNT_W'(list_idx);
    end
  end

  assign addr      = ring_add(front, offset);
  assign front_inc = ring_add(front, CNT_W'(1));
  assign mem_read  = cmd.pop_front | cmd.pop_back | cmd.list_step;
  assign emit      = mem_read | cmd.push_front | cmd.push_back | cmd.report;

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CNT_W'(CAPACITY));
  assign stat.list_last = ((CNT_W'(list_idx) + CNT_W'(1)) == count);
  assign stat.out_free  = !out_valid || out_ready;

  // Store write and registered read into the output value.
  always_ff @(posedge clk) begin
    if (cmd.push_front || cmd.push_back) begin
      mem[addr] <= push_value;
    end
    if (mem_read) begin
      out_value <= mem[addr];
    end else if (emit) begin
      out_value <= '0;
    end
  end

  // Output status fields travel with the value.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= cmd.report ? cmd.report_status : ST_OK;
      out_last   <= cmd.list_step ? stat.list_last : 1'b1;
    end
  end

  // Pointers, count, list index and the output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      list_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.push_front) begin
        front <= addr;
        count <= count + CNT_W'(1);
      end else if (cmd.push_back) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop_front) begin
        front <= front_inc;
        count <= count - CNT_W'(1);
      end else if (cmd.pop_back) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.list_step) begin
        list_idx <= stat.list_last ? '0 : list_idx + IDX_W'(1);
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push_front, cmd.push_back, cmd.pop_front, cmd.pop_back,
              cmd.list_step, cmd.report}))
    else $error("more than one command in a cycle");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_front || cmd.push_back) |-> !stat.full)
    else $error("push issued into a full store");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_front || cmd.pop_back || cmd.list_step) |-> !stat.empty)
    else $error("read issued on an empty store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !emit)
    else $error("stalled result overwritten");
`endif

endmodule

@@ rtl/dq_ctrl.sv @@
// Controller state machine: decodes requests and sequences list output.
module dq_ctrl import dq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [OPCODE_W-1:0] req_opcode,
  output logic                req_ready,
  input  dq_stat_t            stat,
  output dq_cmd_t             cmd
);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == S_IDLE) && stat.out_free;
  assign accept    = req_valid && req_ready;

  // Command decode and next state.
  always_comb begin
    cmd           = '0;
    cmd.report_status = ST_OK;
    state_next    = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (opcode_t'(req_opcode)) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (stat.full) begin
                cmd.report        = 1'b1;
                cmd.report_status = ST_FULL;
              end else if (opcode_t'(req_opcode) == OP_PUSH_FRONT) begin
                cmd.push_front = 1'b1;
              end else begin
                cmd.push_back = 1'b1;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (stat.empty) begin
                cmd.report        = 1'b1;
                cmd.report_status = ST_EMPTY;
              end else if (opcode_t'(req_opcode) == OP_POP_FRONT) begin
                cmd.pop_front = 1'b1;
              end else begin
                cmd.pop_back = 1'b1;
              end
            end
            OP_LIST: begin
              if (stat.empty) begin
                cmd.report        = 1'b1;
                cmd.report_status = ST_EMPTY;
              end else begin
                cmd.list_step = 1'b1;
                if (!stat.list_last) begin
                  state_next = S_LIST;
                end
              end
            end
            default: begin
              // Undefined opcodes are dropped without a result.
            end
          endcase
        end
      end
      S_LIST: begin
        if (stat.out_free) begin
          cmd.list_step = 1'b1;
          if (stat.list_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_list_holds_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) |-> !req_ready)
    else $error("request accepted during list output");

  a_list_step_free: assert property (@(posedge clk) disable iff (rst)
    cmd.list_step |-> stat.out_free)
    else $error("list step with output register busy");

  a_list_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST && cmd.list_step && stat.list_last) |=> (state == S_IDLE))
    else $error("list did not end after last entry");
`endif

endmodule

@@ rtl/double_ended_queue.sv @@
// Top level of the bounded double-ended queue.
// Push and pop: one request per cycle unless a result stalls; the result is registered the next cycle.
// List: one result per cycle per entry, paced by the single store read port and result stalls;
// new requests are held off until the last listed entry has been registered.
// A stalled result holds the input off until it is taken; ready returns in the cycle it is.
// Synchronous reset empties the queue (front and count to zero); store contents are not cleared.
module double_ended_queue import dq_pkg::*; (
  input logic   clk,
  input logic   rst,
  dq_req_if.sink   request,
  dq_rsp_if.source result
);

  dq_cmd_t  cmd;
  dq_stat_t stat;

  // Sequencing of requests and list output.
  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (request.valid),
    .req_opcode (request.opcode),
    .req_ready  (request.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Store, pointers and result register.
  dq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_value (request.value),
    .out_ready  (result.ready),
    .stat       (stat),
    .out_valid  (result.valid),
    .out_value  (result.value_out),
    .out_status (result.status),
    .out_last   (result.last)
  );

endmodule

@@ tb/tb_double_ended_queue.sv @@
// Self-checking testbench for the bounded double-ended queue.
module tb_double_ended_queue import dq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 80;
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int RANDOM_ITEMS = 340;

  // Opcodes the block does not define; requests carrying them are dropped silently.
  localparam logic [OPCODE_W-1:0] OP_RESERVED_A = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RESERVED_B = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RESERVED_C = 3'd7;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [VALUE_W-1:0] value_out;
    status_t                   status;
    logic                      last;
  } deque_result_t;

  logic clk;
  logic rst;

  dq_req_if req_ch ();
  dq_rsp_if rsp_ch ();

  double_ended_queue uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (rsp_ch)
  );

  // Results still owed by the block, oldest first.
  deque_result_t pending_results[$];

  // Shadow copy of the queue contents.
  logic signed [VALUE_W-1:0] ring_store [CAPACITY];
  int ring_front;
  int ring_count;

  int fail_count = 0;
  int idle_pct   = 30;
  bit hold_off_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  // Result-side ready: random stalls, plus a long hold-off when a test asks for one.
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Compare every accepted result with the oldest expected one.
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value_out %0d status %0d last %0b",
               rsp_ch.value_out, rsp_ch.status, rsp_ch.last);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, rsp_ch.value_out);
          fail_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
          fail_count++;
        end
      end
    end
  end

  function automatic void expect_result(input logic signed [VALUE_W-1:0] v,
                                        input status_t st, input logic is_last);
    deque_result_t r;
    r.value_out = v;
    r.status    = st;
    r.last      = is_last;
    pending_results.push_back(r);
  endfunction

  // Update the shadow queue for one accepted request and queue the results it causes.
  function automatic void compute_deque_results(input logic [OPCODE_W-1:0] op,
                                                input logic signed [VALUE_W-1:0] val);
    int slot;
    case (op)
      OP_PUSH_FRONT: begin
        if (ring_count == CAPACITY) begin
          expect_result('0, ST_FULL, 1'b1);
        end else begin
          ring_front = (ring_front + CAPACITY - 1) % CAPACITY;
          ring_store[ring_front] = val;
          ring_count++;
          expect_result('0, ST_OK, 1'b1);
        end
      end
      OP_PUSH_BACK: begin
        if (ring_count == CAPACITY) begin
          expect_result('0, ST_FULL, 1'b1);
        end else begin
          ring_store[(ring_front + ring_count) % CAPACITY] = val;
          ring_count++;
          expect_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP_FRONT: begin
        if (ring_count == 0) begin
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          expect_result(ring_store[ring_front], ST_OK, 1'b1);
          ring_front = (ring_front + 1) % CAPACITY;
          ring_count--;
        end
      end
      OP_POP_BACK: begin
        if (ring_count == 0) begin
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          expect_result(ring_store[(ring_front + ring_count - 1) % CAPACITY], ST_OK, 1'b1);
          ring_count--;
        end
      end
      OP_LIST: begin
        if (ring_count == 0) begin
          expect_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < ring_count; i++) begin
            slot = (ring_front + i) % CAPACITY;
            expect_result(ring_store[slot], ST_OK, i == ring_count - 1);
          end
        end
      end
      default: begin
        // Reserved opcodes change nothing and produce nothing.
      end
    endcase
  endfunction

  // Offer one request, idling at random first, and record it once accepted.
  task automatic send_request(input logic [OPCODE_W-1:0] op,
                              input logic signed [VALUE_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.value  <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    compute_deque_results(op, val);
  endtask

  // Mostly full-range random values, with the extremes mixed in.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Pops and a list on a freshly reset queue all report empty.
  task automatic test_empty_queue();
    send_request(OP_POP_FRONT, $urandom);
    send_request(OP_POP_BACK, $urandom);
    send_request(OP_LIST, $urandom);
  endtask

  // Push the value extremes at both ends, then read them back.
  task automatic test_value_extremes();
    send_request(OP_PUSH_FRONT, VALUE_MAX);
    send_request(OP_PUSH_BACK, VALUE_MIN);
    send_request(OP_PUSH_FRONT, '1);
    send_request(OP_PUSH_BACK, '0);
    send_request(OP_LIST, $urandom);
    send_request(OP_POP_FRONT, $urandom);
    send_request(OP_POP_BACK, $urandom);
  endtask

  // Reserved opcodes are ignored; the list afterwards shows the contents unchanged.
  task automatic test_reserved_opcodes();
    send_request(OP_RESERVED_A, $urandom);
    send_request(OP_RESERVED_B, $urandom);
    send_request(OP_RESERVED_C, $urandom);
    send_request(OP_LIST, $urandom);
  endtask

  // Fill past capacity while the result side is held off, then list and drain the ends.
  task automatic test_full_with_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_request(i % 2 ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
    end
    hold_off_req = 1'b1;
    send_request(OP_LIST, $urandom);
    for (int i = 0; i < 4; i++) begin
      send_request(i % 2 ? OP_POP_BACK : OP_POP_FRONT, $urandom);
    end
    send_request(OP_LIST, $urandom);
  endtask

  // Random traffic in alternating fill and drain phases so both limits are reached often.
  task automatic test_random_traffic(input int item_total);
    int sent;
    int pick;
    int push_weight;
    sent = 0;
    while (sent < item_total) begin
      idle_pct = (sent < 80) ? 0 : 30;
      push_weight = ((sent / 48) % 2 == 0) ? 62 : 24;
      pick = $urandom_range(99);
      if (pick < 3) begin
        case ($urandom_range(2))
          0:       send_request(OP_RESERVED_A, $urandom);
          1:       send_request(OP_RESERVED_B, $urandom);
          default: send_request(OP_RESERVED_C, $urandom);
        endcase
      end else begin
        if (pick < 11) begin
          send_request(OP_LIST, $urandom);
        end else if (pick < 11 + push_weight) begin
          send_request($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
        end else begin
          send_request($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
        end
        sent++;
      end
    end
    idle_pct = 30;
  endtask

  // Test sequence.
  initial begin
    req_ch.valid  <= 1'b0;
    req_ch.opcode <= OP_PUSH_FRONT;
    req_ch.value  <= '0;
    rst <= 1'b1;
    ring_front = 0;
    ring_count = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queue();
    test_value_extremes();
    test_reserved_opcodes();
    test_full_with_backpressure();
    test_random_traffic(RANDOM_ITEMS);

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
